// ===== rtl/mmfs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_pkg
// shared constants and types of the min/max feature scaler
// ----------------------------------------------------------------------------
package mmfs_pkg;

    localparam int MAX_SAMPLES   = 64;
    localparam int FEATURE_LANES = 4;
    localparam int LANE_SLOTS    = 4;
    localparam int FEAT_W        = 16;
    localparam int SCALED_W      = 17;
    localparam int ADDR_W        = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W         = $clog2(MAX_SAMPLES + 1);
    localparam int SPAN_W        = FEAT_W + 1;
    localparam int QUO_W         = SCALED_W;
    localparam int DIV_STEPS     = QUO_W;
    localparam int STEP_W        = $clog2(DIV_STEPS + 1);
    localparam int STORE_W       = FEAT_W * LANE_SLOTS;
    localparam int CFG_W         = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    typedef logic signed [FEAT_W-1:0] feat_t;
    typedef logic [SCALED_W-1:0]      scaled_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/mmfs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_if
// valid/ready channels of the scaler
// ----------------------------------------------------------------------------
interface mmfs_in_if;
    logic                   valid;
    logic                   ready;
    mmfs_pkg::feat_t        feature_0;
    mmfs_pkg::feat_t        feature_1;
    mmfs_pkg::feat_t        feature_2;
    mmfs_pkg::feat_t        feature_3;
    logic                   last_sample;
    modport source (output valid, feature_0, feature_1, feature_2, feature_3,
                    last_sample, input ready);
    modport sink   (input valid, feature_0, feature_1, feature_2, feature_3,
                    last_sample, output ready);
endinterface

interface mmfs_out_if;
    logic                   valid;
    logic                   ready;
    mmfs_pkg::scaled_t      scaled_0;
    mmfs_pkg::scaled_t      scaled_1;
    mmfs_pkg::scaled_t      scaled_2;
    mmfs_pkg::scaled_t      scaled_3;
    logic                   last_out;
    logic                   dropped_samples;
    modport source (output valid, scaled_0, scaled_1, scaled_2, scaled_3,
                    last_out, dropped_samples, input ready);
    modport sink   (input valid, scaled_0, scaled_1, scaled_2, scaled_3,
                    last_out, dropped_samples, output ready);
endinterface

interface mmfs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mmfs_pkg::CFG_W-1:0]    data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mmfs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_ram
// generic single-port ram, registered read
// ----------------------------------------------------------------------------
module mmfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  wire logic [WIDTH-1:0]                 wdata,
    output logic      [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/mmfs_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mmfs_lane
// one feature lane: restoring divider for (x-min)*65536/(max-min)
// ----------------------------------------------------------------------------
module mmfs_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        enable,
    input  wire mmfs_pkg::feat_t             x,
    input  wire mmfs_pkg::feat_t             lo,
    input  wire mmfs_pkg::feat_t             hi,
    output logic                             busy,
    output mmfs_pkg::scaled_t                result
);
    logic [mmfs_pkg::SPAN_W-1:0]  span_reg;
    logic [mmfs_pkg::SPAN_W:0]    rem_reg, rem_next, diff;
    logic [mmfs_pkg::QUO_W-1:0]   quo_reg;
    logic [mmfs_pkg::STEP_W-1:0]  step_reg;
    logic                         zero_reg, q_bit;
    logic [mmfs_pkg::SPAN_W-1:0]  span_w, num_w;

    assign span_w = mmfs_pkg::SPAN_W'(signed'({hi[mmfs_pkg::FEAT_W-1], hi})
                    - signed'({lo[mmfs_pkg::FEAT_W-1], lo}));
    assign num_w  = mmfs_pkg::SPAN_W'(signed'({x[mmfs_pkg::FEAT_W-1], x})
                    - signed'({lo[mmfs_pkg::FEAT_W-1], lo}));

    // remainder starts as the numerator, which never exceeds the span
    // quotient bits come out msb first
    always_comb
    begin
        q_bit    = (rem_reg >= {1'b0, span_reg});
        diff     = q_bit ? (rem_reg - {1'b0, span_reg}) : rem_reg;
        rem_next = {diff[mmfs_pkg::SPAN_W-1:0], 1'b0};
    end

    assign busy   = (step_reg != '0);
    assign result = (zero_reg) ? '0 : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= mmfs_pkg::STEP_W'(mmfs_pkg::DIV_STEPS);
        end
        else if (busy)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            span_reg <= span_w;
            rem_reg  <= {1'b0, num_w};
            quo_reg  <= '0;
            zero_reg <= !enable || ($signed(hi) <= $signed(lo));
        end
        else if (busy)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[mmfs_pkg::QUO_W-2:0], q_bit};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/min_max_feature_scaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_feature_scaler
// stores a data set, tracks per-lane min/max, emits scaled samples
// flow: loading stores the incoming samples; each emitted sample is read back
// from ram, takes 17 divider steps, then is registered for the output channel
// throughput: one sample per cycle while loading; the next stored sample is not
// read until the sink takes the result; the four bit-serial lane dividers work side by side
// reset: async active low; min/max set to 7fff/8000, count, overflow cleared, register to 4
// ----------------------------------------------------------------------------
module min_max_feature_scaler (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mmfs_in_if.sink            in_ch,
    mmfs_out_if.source         out_ch,
    mmfs_cfg_if.sink           cfg
);
    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    localparam int L = mmfs_pkg::LANE_SLOTS;
    localparam int W = mmfs_pkg::FEAT_W;

    state_t state_reg, state_next;
    logic [mmfs_pkg::CFG_W-1:0]   cfg_reg;
    logic [mmfs_pkg::CNT_W-1:0]   count_reg, rd_reg;
    logic                         ovf_reg, wait_reg;
    mmfs_pkg::feat_t              min_reg [L];
    mmfs_pkg::feat_t              max_reg [L];
    mmfs_pkg::feat_t              feat_in [L];
    mmfs_pkg::scaled_t            res [L];
    mmfs_pkg::scaled_t            out_reg [L];
    logic                         last_reg;
    logic [L-1:0]                 lane_busy;
    logic [mmfs_pkg::STORE_W-1:0] wdata, rdata;
    logic [mmfs_pkg::ADDR_W-1:0]  addr;
    logic                         we, in_fire, start, room;
    logic [2:0]                   n_act;
    mmfs_pkg::lane_ctl_t          ctl;

    assign feat_in[0] = in_ch.feature_0;
    assign feat_in[1] = in_ch.feature_1;
    assign feat_in[2] = in_ch.feature_2;
    assign feat_in[3] = in_ch.feature_3;
    assign wdata = {in_ch.feature_3, in_ch.feature_2, in_ch.feature_1, in_ch.feature_0};

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = (state_reg == ST_LOAD);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign room        = (count_reg < mmfs_pkg::CNT_W'(mmfs_pkg::MAX_SAMPLES));
    assign we          = in_fire && room;
    assign addr        = (state_reg == ST_LOAD) ? count_reg[mmfs_pkg::ADDR_W-1:0]
                                                : rd_reg[mmfs_pkg::ADDR_W-1:0];

    always_comb
    begin
        n_act = cfg_reg;
        if (n_act == 3'd0) n_act = 3'd1;
        if (n_act > 3'(mmfs_pkg::FEATURE_LANES)) n_act = 3'(mmfs_pkg::FEATURE_LANES);
    end

    assign ctl.start = (state_reg == ST_READ) && wait_reg;
    assign ctl.busy  = |lane_busy;
    assign ctl.done  = (state_reg == ST_DIV) && !ctl.busy;
    assign start     = ctl.start;

    mmfs_ram #(.WIDTH(mmfs_pkg::STORE_W), .DEPTH(mmfs_pkg::MAX_SAMPLES)) u_store (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    for (genvar g = 0; g < L; g++)
    begin : g_lane
        mmfs_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (start),
            .enable ((g < mmfs_pkg::FEATURE_LANES) && (3'(g) < n_act)),
            .x      (rdata[g*W +: W]),
            .lo     (min_reg[g]),
            .hi     (max_reg[g]),
            .busy   (lane_busy[g]),
            .result (res[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (in_fire && in_ch.last_sample)
                     begin
                         state_next = ((count_reg != '0) || room) ? ST_READ : ST_LOAD;
                     end
            ST_READ: if (wait_reg) state_next = ST_DIV;
            ST_DIV:  if (ctl.done) state_next = ST_OUT;
            ST_OUT:  if (out_ch.ready)
                     begin
                         state_next = last_reg ? ST_LOAD : ST_READ;
                     end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cfg_reg   <= mmfs_pkg::CFG_RESET;
            count_reg <= '0;
            rd_reg    <= '0;
            ovf_reg   <= 1'b0;
            wait_reg  <= 1'b0;
            for (int i = 0; i < L; i++)
            begin
                min_reg[i] <= 16'sh7fff;
                max_reg[i] <= 16'sh8000;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid) cfg_reg <= cfg.data;
            wait_reg <= (state_next == ST_READ) && (state_reg == ST_READ) ? 1'b1 :
                        1'b0;
            if (we)
            begin
                count_reg <= count_reg + 1'b1;
                for (int i = 0; i < mmfs_pkg::FEATURE_LANES; i++)
                begin
                    if (feat_in[i] < min_reg[i]) min_reg[i] <= feat_in[i];
                    if (feat_in[i] > max_reg[i]) max_reg[i] <= feat_in[i];
                end
            end
            else if (in_fire)
            begin
                ovf_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && out_ch.ready)
            begin
                if (last_reg)
                begin
                    rd_reg    <= '0;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    for (int i = 0; i < L; i++)
                    begin
                        min_reg[i] <= 16'sh7fff;
                        max_reg[i] <= 16'sh8000;
                    end
                end
                else
                begin
                    rd_reg <= rd_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done)
        begin
            for (int i = 0; i < L; i++) out_reg[i] <= res[i];
            last_reg <= (rd_reg + 1'b1 == count_reg);
        end
    end

    assign out_ch.valid           = (state_reg == ST_OUT);
    assign out_ch.scaled_0        = out_reg[0];
    assign out_ch.scaled_1        = out_reg[1];
    assign out_ch.scaled_2        = out_reg[2];
    assign out_ch.scaled_3        = out_reg[3];
    assign out_ch.last_out        = last_reg;
    assign out_ch.dropped_samples = ovf_reg;
endmodule
`default_nettype wire
